// ===== src/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, widths and constants of the escape-time block.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int FRACTION_BITS = 28;

  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 13;
  localparam int ITER_W   = 16;
  localparam int INDEX_W  = 24;

  localparam int FX_W       = FRACTION_BITS + 4;
  localparam int PROD_W     = 2 * FX_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int AXIS_W     = INDEX_W + 4;
  localparam int MAG_KEEP   = WIDTH_W + 3;
  localparam int DIVIDEND_W = FRACTION_BITS + MAG_KEEP;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd160;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd50;
  localparam logic [ITER_W-1:0]   ITER_RESET   = 16'd1000;

  localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(1) << (2 * FRACTION_BITS + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_IDX,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_SQR,
    ST_SQI,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(FX_MAX);
    lo = SUM_W'(FX_MIN);
    if (v > hi) begin
      return FX_MAX;
    end else if (v < lo) begin
      return FX_MIN;
    end else begin
      return v[FX_W-1:0];
    end
  endfunction

endpackage

// ===== src/met_pixel_if.sv =====
// ----------------------------------------------------------------------------
// met_pixel_if
// Pixel channel: one word is a linear pixel index and a batch end flag.
// ----------------------------------------------------------------------------
interface met_pixel_if;
  import met_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic               last_pixel;

  modport source (output valid, output pixel_index, output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input last_pixel, output ready);
endinterface

// ===== src/met_count_if.sv =====
// ----------------------------------------------------------------------------
// met_count_if
// Result channel: one word is an iteration count and a batch end flag.
// ----------------------------------------------------------------------------
interface met_count_if;
  import met_pkg::*;

  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iteration_count;
  logic              last_out;

  modport source (output valid, output iteration_count, output last_out, input ready);
  modport sink (input valid, input iteration_count, input last_out, output ready);
endinterface

// ===== src/met_div.sv =====
// ----------------------------------------------------------------------------
// met_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// pixel split and both axis mappings.
// ----------------------------------------------------------------------------
module met_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [met_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [met_pkg::WIDTH_W-1:0]    divisor,
  output logic                          done,
  output logic [met_pkg::DIVIDEND_W-1:0] quotient,
  output logic [met_pkg::WIDTH_W-1:0]    remainder
);
  import met_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] acc;
  logic [WIDTH_W-1:0]    rem;
  logic [WIDTH_W-1:0]    dsr;

  logic [WIDTH_W:0]      trial;
  logic                  fits;
  logic [WIDTH_W:0]      diff;
  logic [WIDTH_W-1:0]    rem_next;
  logic [DIVIDEND_W-1:0] acc_next;

  always_comb begin
    trial    = {rem, acc[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, dsr};
    diff     = trial - {1'b0, dsr};
    rem_next = fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
    acc_next = {acc[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc;
  assign remainder = rem;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one pixel: index split, mapping to c, z = z*z + c.
// ----------------------------------------------------------------------------
// One pixel at a time. Setup runs three divisions on a shared bit-serial
// divider (index by width, then each axis), then each iteration runs zr^2,
// zi^2 and zr*zi in turn on one shared 32x32 multiplier and then updates z.
// The imaginary axis division is skipped when that part saturates, and a
// zero width skips setup and iteration. A finished count waits while the
// output word is still held; the next pixel is taken while the previous
// count waits at the output.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]  cfg_data,
  met_pixel_if.sink                      pixel,
  met_count_if.source                    result
);
  import met_pkg::*;

  state_t state;
  state_t state_next;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [ITER_W-1:0]   max_iterations;

  logic [INDEX_W-1:0]    y_row;
  logic                  axis_neg_r;
  logic signed [FX_W-1:0] cre;
  logic signed [FX_W-1:0] cim;
  logic signed [FX_W-1:0] zr;
  logic signed [FX_W-1:0] zi;
  logic signed [PROD_W-1:0] sr;
  logic signed [PROD_W-1:0] si;
  logic signed [PROD_W-1:0] pr;
  logic [ITER_W-1:0]     iter;
  logic                  last_r;

  logic                  out_valid;
  logic [ITER_W-1:0]     out_count;
  logic                  out_last;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [WIDTH_W-1:0]    div_rem;

  logic                  accept;
  logic                  out_free;

  logic [INDEX_W-1:0]     axis_coord;
  logic [WIDTH_W-1:0]     axis_span;
  logic signed [AXIS_W-1:0] axis_num;
  logic                   axis_neg;
  logic [AXIS_W-1:0]      axis_mag;
  logic                   axis_sat;
  logic [DIVIDEND_W-1:0]  axis_dividend;
  logic [FX_W-1:0]        quot_ext;
  logic signed [FX_W-1:0] axis_c;

  logic signed [FX_W-1:0]   mul_a;
  logic signed [FX_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         mag_sum;
  logic                     escaped;
  logic signed [SUM_W-1:0]  sq_diff;
  logic signed [SUM_W-1:0]  nre;
  logic signed [SUM_W-1:0]  nim;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;

  met_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (image_width),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      max_iterations <= ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[HEIGHT_W-1:0];
        CFG_MAX_ITERATIONS: max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept       = (state == ST_IDLE) && pixel.valid;
  assign out_free     = !out_valid || result.ready;
  assign pixel.ready  = (state == ST_IDLE);

  // axis mapping: num = 4*coord - 2*span, c = num / width in Q4.28
  always_comb begin
    axis_coord = (state == ST_DIV_IDX) ? INDEX_W'(div_rem) : y_row;
    axis_span  = (state == ST_DIV_IDX) ? image_width : image_height;
    axis_num   = $signed({2'b00, axis_coord, 2'b00})
               - $signed({{(AXIS_W-WIDTH_W-1){1'b0}}, axis_span, 1'b0});
    axis_neg   = axis_num[AXIS_W-1];
    axis_mag   = axis_neg ? AXIS_W'(-axis_num) : AXIS_W'(axis_num);
    axis_sat   = axis_mag >= {{(AXIS_W-WIDTH_W-3){1'b0}}, image_width, 3'b000};
    axis_dividend = {axis_mag[MAG_KEEP-1:0], {FRACTION_BITS{1'b0}}};
    quot_ext   = {1'b0, div_quot[FX_W-2:0]};
    axis_c     = axis_neg_r ? -$signed(quot_ext) : $signed(quot_ext);
  end

  // shared multiplier and update
  always_comb begin
    mul_a   = (state == ST_SQI) ? zi : zr;
    mul_b   = (state == ST_SQR) ? zr : zi;
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    mag_sum = SUM_W'(unsigned'(sr)) + SUM_W'(unsigned'(si));
    escaped = mag_sum > ESC_LIMIT;
    sq_diff = SUM_W'(sr) - SUM_W'(si);
    nre     = sq_diff >>> FRACTION_BITS;
    nim     = SUM_W'(pr) >>> (FRACTION_BITS - 1);
    sum_re  = nre + SUM_W'(cre);
    sum_im  = nim + SUM_W'(cim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = axis_dividend;
    case (state)
      ST_IDLE: begin
        div_dividend = {{(DIVIDEND_W-INDEX_W){1'b0}}, pixel.pixel_index};
        if (pixel.valid) begin
          if (image_width == '0) begin
            state_next = ST_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV_IDX;
          end
        end
      end
      ST_DIV_IDX: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_RE;
        end
      end
      ST_DIV_RE: begin
        if (div_done) begin
          if (axis_sat) begin
            state_next = ST_SQR;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV_IM;
          end
        end
      end
      ST_DIV_IM: begin
        if (div_done) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        state_next = (iter < max_iterations) ? ST_SQI : ST_DONE;
      end
      ST_SQI: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = escaped ? ST_DONE : ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_SQR;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= pixel.last_pixel;
      iter   <= '0;
      zr     <= '0;
      zi     <= '0;
    end
    if (state == ST_DIV_IDX && div_done) begin
      y_row      <= div_quot[INDEX_W-1:0];
      axis_neg_r <= axis_neg;
    end
    if (state == ST_DIV_RE && div_done) begin
      cre        <= axis_c;
      axis_neg_r <= axis_neg;
      if (axis_sat) begin
        cim <= axis_neg ? FX_MIN : FX_MAX;
      end
    end
    if (state == ST_DIV_IM && div_done) begin
      cim <= axis_c;
    end
    if (state == ST_SQR) begin
      sr <= prod;
    end
    if (state == ST_SQI) begin
      si <= prod;
    end
    if (state == ST_MUL) begin
      pr <= prod;
    end
    if (state == ST_UPD) begin
      zr   <= sat_fx(sum_re);
      zi   <= sat_fx(sum_im);
      iter <= iter + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_count <= iter;
      out_last  <= last_r;
    end
  end

  assign result.valid           = out_valid;
  assign result.iteration_count = out_count;
  assign result.last_out        = out_last;

endmodule

// ===== verif/mandelbrot_escape_time_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Drives pixel words into the escape-time block and compares every count word
// with an independent fixed-point model of the iteration, over many image
// sizes and iteration limits and under random stalls on both channels.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;
  import met_pkg::*;

  localparam int     FB            = FRACTION_BITS;
  localparam int     SETTLE_CYCLES = 300;
  localparam int     HOLD_CYCLES   = 3000;
  localparam longint RUN_LIMIT     = 3_000_000;
  localparam longint FX_HI         = (longint'(1) << (FB + 3)) - 1;
  localparam longint FX_LO         = -(longint'(1) << (FB + 3));

  typedef logic signed [127:0] acc_t;
  localparam acc_t ESCAPE_SQ = acc_t'(1) <<< (2 * FB + 2);

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               last;
  } pixel_word_t;

  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic              last;
  } count_word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  met_pixel_if pix_bus ();
  met_count_if cnt_bus ();

  mandelbrot_escape_time dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_bus),
    .result    (cnt_bus)
  );

  logic [WIDTH_W-1:0]  img_w;
  logic [HEIGHT_W-1:0] img_h;
  logic [ITER_W-1:0]   iter_limit;

  pixel_word_t pixels_to_send[$];
  count_word_t counts_due[$];
  pixel_word_t next_pixel;
  count_word_t got;
  count_word_t want;
  int          pixels_queued = 0;
  int          pixels_taken  = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_armed    = 1'b0;
  bit          hold_done     = 1'b0;
  int          hold_left     = 0;
  longint      cycle_count   = 0;

  function automatic longint clamp_fx(input acc_t v);
    if (v > FX_HI) return FX_HI;
    if (v < FX_LO) return FX_LO;
    return longint'(v);
  endfunction

  // num / w in Q4.28, truncated toward zero, saturated
  function automatic longint axis_to_fx(input longint num, input longint w);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    if (m >= 8 * w) return (num < 0) ? FX_LO : FX_HI;
    q = (m <<< FB) / w;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [ITER_W-1:0] escape_count(input logic [INDEX_W-1:0] idx);
    longint      w;
    longint      h;
    longint      x;
    longint      y;
    longint      cre;
    longint      cim;
    acc_t        zr;
    acc_t        zi;
    acc_t        sq_re;
    acc_t        sq_im;
    acc_t        mix;
    int unsigned n;
    if (img_w == 0) return '0;
    w   = img_w;
    h   = img_h;
    x   = longint'(idx) % w;
    y   = longint'(idx) / w;
    cre = axis_to_fx(4 * x - 2 * w, w);
    cim = axis_to_fx(4 * y - 2 * h, w);
    zr  = 0;
    zi  = 0;
    n   = 0;
    while (n < iter_limit) begin
      sq_re = zr * zr;
      sq_im = zi * zi;
      if (sq_re + sq_im > ESCAPE_SQ) break;
      mix = (zr * zi) <<< 1;
      zr  = clamp_fx(((sq_re - sq_im) >>> FB) + cre);
      zi  = clamp_fx((mix >>> FB) + cim);
      n++;
    end
    return ITER_W'(n);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        counts_due.push_back('{escape_count(pix_bus.pixel_index), pix_bus.last_pixel});
        pixels_taken++;
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pixel = pixels_to_send.pop_front();
          pix_bus.pixel_index <= next_pixel.idx;
          pix_bus.last_pixel  <= next_pixel.last;
          pix_bus.valid       <= 1'b1;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // count monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      cnt_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (cnt_bus.valid && cnt_bus.ready) begin
        got = '{cnt_bus.iteration_count, cnt_bus.last_out};
        if (counts_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected count word, got count %0d last %0b",
                   $time, got.count, got.last);
        end else begin
          want = counts_due.pop_front();
          if (got.count !== want.count) begin
            mismatches++;
            $display("%0t: iteration_count expected %0d, actual %0d",
                     $time, want.count, got.count);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last_out expected %0b, actual %0b", $time, want.last, got.last);
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        cnt_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        cnt_bus.ready <= 1'b0;
      end else begin
        cnt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_pixel(input int unsigned idx, input bit last);
    pixels_to_send.push_back('{INDEX_W'(idx), last});
    pixels_queued++;
  endtask

  task automatic wait_drained();
    while (pixels_taken != pixels_queued || counts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int w, input int h, input int lim);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_MAX_ITERATIONS;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_we     <= 1'b0;
    img_w      = WIDTH_W'(w);
    img_h      = HEIGHT_W'(h);
    iter_limit = ITER_W'(lim);
  endtask

  // mostly in-image batches, some full-range noise
  task automatic queue_random_pixels(input int n);
    int unsigned area;
    int          batch_left;
    batch_left = 0;
    area = int'(img_w) * int'(img_h);
    if (area > (1 << INDEX_W) || area == 0) area = 1 << INDEX_W;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        queue_pixel($urandom_range((1 << INDEX_W) - 1), 1'($urandom_range(1)));
      end else begin
        if (batch_left == 0) batch_left = $urandom_range(16, 1);
        batch_left--;
        queue_pixel($urandom_range(area - 1), batch_left == 0);
      end
    end
  endtask

  int set_w   [6] = '{160, 64, 8191, 1, 37, 4096};
  int set_h   [6] = '{50, 48, 8191, 4096, 23, 4096};
  int set_lim [6] = '{64, 200, 24, 16, 120, 8};

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_IMAGE_WIDTH;
    cfg_data            = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_index = '0;
    pix_bus.last_pixel  = 1'b0;
    cnt_bus.ready       = 1'b0;
    img_w               = WIDTH_RESET;
    img_h               = HEIGHT_RESET;
    iter_limit          = ITER_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 12;
    recv_idle_pct = 80;

    // reset settings: corners, center point in the set, a row far below the image
    queue_pixel(0, 1'b0);
    queue_pixel(25 * 160 + 80, 1'b1);
    queue_pixel(159, 1'b0);
    queue_pixel(25 * 160 + 40, 1'b0);
    queue_pixel(7999, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b1);

    // zero width gives a zero count
    apply_setting(0, 50, 1000);
    queue_pixel(5, 1'b1);
    queue_pixel(24'hFFFFFF, 1'b0);

    // origin and c = -2i at the largest limit
    apply_setting(2, 2, 65535);
    queue_pixel(3, 1'b0);
    queue_pixel(1, 1'b1);

    // zero limit, widest image
    apply_setting(8191, 8191, 0);
    queue_pixel(123456, 1'b0);
    queue_pixel(0, 1'b1);

    // limit of one, zero height
    apply_setting(8191, 0, 1);
    queue_pixel(0, 1'b0);
    queue_pixel(8190, 1'b0);
    queue_pixel(4095, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b1);

    // one column, tall image
    apply_setting(1, 4096, 30);
    queue_pixel(0, 1'b0);
    queue_pixel(2048, 1'b0);
    queue_pixel(2047, 1'b0);
    queue_pixel(4096, 1'b1);

    for (int s = 0; s < 6; s++) begin
      apply_setting(set_w[s], set_h[s], set_lim[s]);
      case (s / 2)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (s == 4) hold_armed = 1'b1;
      queue_random_pixels(100);
    end

    wait_drained();
    if (mismatches == 0 && counts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
